/* hdl/pdr_pkg.sv */
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants, codes, types and the glyph ramp of the point-density
// raster.
// ----------------------------------------------------------------------------
`default_nettype none

package pdr_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_SATURATION = 8;

    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W  = 4;
    localparam int GLYPH_W  = 7;
    localparam int COORD_W  = 16;
    localparam int RROW_W   = 6;
    localparam int RCOL_W   = 7;
    localparam int OPCODE_W = 2;
    localparam int KIND_W   = 2;

    localparam logic [WIDTH_W-1:0]  RST_GRID_WIDTH  = 8'd80;
    localparam logic [HEIGHT_W-1:0] RST_GRID_HEIGHT = 7'd40;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PLOT  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // Work kinds handed from the front to the back.
    localparam logic [KIND_W-1:0] K_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] K_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] K_PLOT  = 2'd2;
    localparam logic [KIND_W-1:0] K_READ  = 2'd3;

    typedef struct packed {
        logic init_busy;
    } pdr_status_t;

    function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [COUNT_W-1:0] count);
        logic [GLYPH_W-1:0] g;
        unique case (count)
            4'd0:       g = 7'h20;
            4'd1:       g = 7'h2E;
            4'd2:       g = 7'h3A;
            4'd3:       g = 7'h2D;
            4'd4:       g = 7'h7E;
            4'd5:       g = 7'h2B;
            4'd6, 4'd7: g = 7'h2A;
            default:    g = 7'h23;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* hdl/pdr_if.sv */
// ----------------------------------------------------------------------------
// pdr_if
// Valid/ready channels of the point-density raster: input items, results
// and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdr_item_if import pdr_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [RROW_W-1:0]          read_row;
    logic [RCOL_W-1:0]          read_col;

    modport source (output valid, opcode, point_x, point_y, read_row, read_col,
                    input ready);
    modport sink   (input valid, opcode, point_x, point_y, read_row, read_col,
                    output ready);
endinterface

interface pdr_result_if import pdr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [GLYPH_W-1:0]   glyph;
    logic [COUNT_W-1:0]   hit_count;
    logic                 plotted;

    modport source (output valid, glyph, hit_count, plotted, input ready);
    modport sink   (input valid, glyph, hit_count, plotted, output ready);
endinterface

interface pdr_cfg_if import pdr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/pdr_ram.sv */
// ----------------------------------------------------------------------------
// pdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/pdr_front.sv */
// ----------------------------------------------------------------------------
// pdr_front
// Holds the size registers, accepts input words, bounds-checks them and
// turns each into a work kind and a cell address for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_front import pdr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int CMD_W  = KIND_W + ADDR_W
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pdr_item_if.sink         item,
    pdr_cfg_if.sink          cfg,
    input  wire pdr_status_t status,
    input  wire logic        q_full,
    output logic             q_push,
    output logic [CMD_W-1:0] q_data
);

    logic [WIDTH_W-1:0]  grid_width_reg, grid_width_next;
    logic [HEIGHT_W-1:0] grid_height_reg, grid_height_next;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic signed [17:0]  xs, ys, lim_x, lim_y, col_sum, row_sum;
    logic                keep_plot, keep_read;
    logic [WIDTH_W-1:0]  col_sel;
    logic [HEIGHT_W-1:0] row_sel;
    logic [ADDR_W-1:0]   cell_addr;
    logic [KIND_W-1:0]   kind;

    assign cfg.ready  = 1'b1;
    assign item.ready = !q_full && !status.init_busy;
    assign q_push     = item.valid && item.ready;

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:  grid_width_next  = cfg.data;
                REG_GRID_HEIGHT: grid_height_next = cfg.data[HEIGHT_W-1:0];
                default:         grid_width_next  = grid_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    always_comb
    begin
        w_eff = (int'(grid_width_reg) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : grid_width_reg;
        h_eff = (int'(grid_height_reg) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT)
                                                     : grid_height_reg;

        xs      = 18'(item.point_x);
        ys      = 18'(item.point_y);
        lim_x   = $signed({6'd0, w_eff, 4'd0});
        lim_y   = $signed({6'd0, h_eff, 5'd0});
        col_sum = lim_x + xs;
        row_sum = lim_y + ys;

        keep_plot = (xs > -lim_x) && (xs < lim_x) && (ys > -lim_y) && (ys < lim_y);
        keep_read = ({1'b0, item.read_row} < h_eff) && ({1'b0, item.read_col} < w_eff);

        if (item.opcode == OP_PLOT)
        begin
            col_sel = col_sum[12:5];
            row_sel = row_sum[12:6];
        end
        else
        begin
            col_sel = {1'b0, item.read_col};
            row_sel = {1'b0, item.read_row};
        end

        cell_addr = ADDR_W'(row_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_sel);

        unique case (item.opcode)
            OP_CLEAR: kind = K_CLEAR;
            OP_PLOT:  kind = keep_plot ? K_PLOT : K_NONE;
            OP_READ:  kind = keep_read ? K_READ : K_NONE;
            default:  kind = K_NONE;
        endcase
    end

    assign q_data = {kind, cell_addr};

endmodule

`default_nettype wire

/* hdl/pdr_queue.sv */
// ----------------------------------------------------------------------------
// pdr_queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_queue #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/pdr_back.sv */
// ----------------------------------------------------------------------------
// pdr_back
// Executes queued work against the hit-count RAM: read-modify-write for
// plots, reads with glyph lookup, and the clearing sweep. Owns the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_back import pdr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SATURATION = DEF_SATURATION,
    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W = $clog2(CELLS),
    localparam int CMD_W  = KIND_W + ADDR_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire logic [CMD_W-1:0] q_data,
    output logic                  q_pop,
    output pdr_status_t           status,
    pdr_result_if.source          result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    logic [1:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic                init_reg, init_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0]  glyph_reg, glyph_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                plotted_reg, plotted_next;

    logic [KIND_W-1:0]   head_kind;
    logic [ADDR_W-1:0]   head_addr;
    logic                out_free, load;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata, ram_rdata, bumped;

    assign head_kind = q_data[CMD_W-1 -: KIND_W];
    assign head_addr = q_data[ADDR_W-1:0];
    assign out_free  = !out_valid_reg || result.ready;
    assign bumped    = (ram_rdata < COUNT_W'(SATURATION)) ? ram_rdata + 1'b1 : ram_rdata;

    assign status.init_busy = init_reg;

    pdr_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        init_next    = init_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = '0;
        load         = 1'b0;
        glyph_next   = '0;
        count_next   = '0;
        plotted_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop     = 1'b1;
                    kind_next = head_kind;
                    addr_next = head_addr;
                    unique case (head_kind)
                        K_PLOT, K_READ: state_next = ST_WAIT;
                        K_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                            sweep_next = '0;
                        end
                        default:        load = 1'b1;
                    endcase
                end
            end
            ST_WAIT:
            begin
                load       = 1'b1;
                state_next = ST_IDLE;
                if (kind_reg == K_PLOT)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = bumped;
                    count_next   = bumped;
                    plotted_next = 1'b1;
                end
                else
                begin
                    count_next = ram_rdata;
                    glyph_next = ramp_glyph(ram_rdata);
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                    load       = !init_reg;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            init_reg      <= 1'b1;
            kind_reg      <= K_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            init_reg      <= init_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (load)
        begin
            glyph_reg   <= glyph_next;
            count_reg   <= count_next;
            plotted_reg <= plotted_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.glyph     = glyph_reg;
    assign result.hit_count = count_reg;
    assign result.plotted   = plotted_reg;

endmodule

`default_nettype wire

/* hdl/point_density_raster.sv */
// ----------------------------------------------------------------------------
// point_density_raster
// Grid of saturating 4-bit hit counters with plot, clear and glyph read.
//
//   Channel  Dir  Contents
//   item     in   opcode, point_x, point_y, read_row, read_col
//   result   out  glyph, hit_count, plotted
//   cfg      in   index (0 grid_width, 1 grid_height), data
//
// A plot or in-range read runs in the back end as a RAM read, then the
// write back (plots only) and the result; the next word waits until then.
// An out-of-range or unused word is finished in ST_IDLE with a zero result.
// A clear sweeps the RAM one cell a cycle and then loads a result.
// After reset the same sweep runs with item.ready low and loads no result;
// cfg writes are taken throughout.
// A two-word queue lets the front take words while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module point_density_raster import pdr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SATURATION = DEF_SATURATION
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pdr_item_if.sink     item,
    pdr_result_if.source result,
    pdr_cfg_if.sink      cfg
);

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CMD_W  = KIND_W + ADDR_W;

    pdr_status_t      status;
    logic             q_push, q_pop, q_full, q_empty;
    logic [CMD_W-1:0] q_in, q_out;

    pdr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .status (status),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    pdr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    pdr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SATURATION (SATURATION)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .status  (status),
        .result  (result)
    );

endmodule

`default_nettype wire

/* hdl/pdr_checker.sv */
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level assertions for the point-density raster, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_checker import pdr_pkg::*; #(
    parameter int SATURATION = DEF_SATURATION
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic [GLYPH_W-1:0] result_glyph,
    input wire logic [COUNT_W-1:0] result_hit_count,
    input wire logic               result_plotted
);

    // The clearing sweep after reset keeps the input closed.
    a_init_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !item_ready)
        else $error("input ready during the clearing sweep after reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_glyph)
            && $stable(result_hit_count) && $stable(result_plotted))
        else $error("stalled result word changed");

    a_plot_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_plotted |-> result_glyph == '0
            && result_hit_count != '0 && result_hit_count <= COUNT_W'(SATURATION))
        else $error("plotted word with bad glyph or count");

    a_glyph_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_plotted && result_glyph != '0
            |-> result_glyph == ramp_glyph(result_hit_count))
        else $error("glyph does not match hit count");

endmodule

bind point_density_raster pdr_checker #(
    .SATURATION (SATURATION)
) u_pdr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_glyph     (result.glyph),
    .result_hit_count (result.hit_count),
    .result_plotted   (result.plotted)
);

`default_nettype wire
